/* src/drpc_pkg.sv */
package drpc_pkg;

    // Fault thresholds
    localparam logic [3:0] EVENT_LIMIT   = 4'd10;
    localparam logic [2:0] TICK_LIMIT    = 3'd5;
    localparam logic [7:0] SPACING_SAT   = 8'hff;

    // Action codes
    localparam logic ACT_EVENT = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // Switch codes; previous-switch register holds SW_NONE after reset
    localparam logic [1:0] SW_ONE  = 2'd0;
    localparam logic [1:0] SW_TWO  = 2'd1;
    localparam logic [1:0] SW_NONE = 2'd2;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_WEIGHT      = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FLOW_INTERVAL = 1'd1;

    // Configuration reset values
    localparam logic [7:0] PULSE_WEIGHT_RST      = 8'd1;
    localparam logic [7:0] MAX_FLOW_INTERVAL_RST = 8'd0;

    typedef struct packed {
        logic        action;
        logic        which_switch;
        logic        switch_one_level;
        logic        switch_two_level;
        logic        valve_closed;
        logic [31:0] now_seconds;
    } item_t;

    typedef struct packed {
        logic [7:0]  increment;
        logic        magnetic_fault;
        logic        stuck_reed_fault;
        logic        valve_leak_fault;
        logic        over_flow_fault;
        logic [7:0]  minute_sum;
        logic [15:0] hour_sum;
        logic [31:0] total_sum;
    } result_t;

    typedef struct packed {
        logic [7:0] pulse_weight;
        logic [7:0] max_flow_interval;
    } cfg_t;

endpackage

/* src/drpc_core.sv */
module drpc_core
    import drpc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    step,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    typedef struct packed {
        logic [3:0] cnt;
        logic       flag;
    } bump_t;

    // One step toward a fault: count while unflagged, flag once past the limit
    function automatic bump_t bump(input logic [3:0] cnt, input logic flag);
        bump_t      r;
        logic [3:0] inc;
        inc    = cnt + 4'd1;
        r.cnt  = inc;
        r.flag = flag;
        if (flag)
        begin
            r.cnt = '0;
        end
        else if (inc > EVENT_LIMIT)
        begin
            r.cnt  = '0;
            r.flag = 1'b1;
        end
        return r;
    endfunction

    logic [3:0]  mag_event_cnt_reg, mag_event_cnt_next;
    logic [2:0]  mag_tick_cnt_reg, mag_tick_cnt_next;
    logic [3:0]  repeat_cnt_reg, repeat_cnt_next;
    logic [3:0]  valve_cnt_reg, valve_cnt_next;
    logic [3:0]  flow_cnt_reg, flow_cnt_next;
    logic [1:0]  prev_switch_reg, prev_switch_next;
    logic        armed_reg, armed_next;
    logic [31:0] last_pulse_reg, last_pulse_next;
    logic        mag_flag_reg, mag_flag_next;
    logic        stuck_flag_reg, stuck_flag_next;
    logic        leak_flag_reg, leak_flag_next;
    logic        flow_flag_reg, flow_flag_next;
    logic [7:0]  minute_reg, minute_next;
    logic [15:0] hour_reg, hour_next;
    logic [31:0] total_reg, total_next;

    logic        both_low;
    logic [1:0]  this_switch;
    logic [2:0]  tick_inc;
    logic [31:0] delta;
    logic [7:0]  spacing;
    logic [7:0]  inc;
    bump_t       b_mag, b_rep, b_valve, b_flow;

    assign both_low    = !item.switch_one_level && !item.switch_two_level;
    assign this_switch = {1'b0, item.which_switch};
    assign tick_inc    = mag_tick_cnt_reg + 3'd1;
    assign delta       = item.now_seconds - last_pulse_reg;
    assign b_mag       = bump(mag_event_cnt_reg, mag_flag_reg);
    assign b_rep       = bump(repeat_cnt_reg, stuck_flag_reg);
    assign b_valve     = bump(valve_cnt_reg, leak_flag_reg);
    assign b_flow      = bump(flow_cnt_reg, flow_flag_reg);

    // Spacing since the last counted pulse, saturated; zero if time has not moved on
    always_comb
    begin
        spacing = '0;
        if (item.now_seconds > last_pulse_reg)
        begin
            spacing = (delta[31:8] != '0) ? SPACING_SAT : delta[7:0];
        end
    end

    // Next-state logic for one item
    always_comb
    begin
        mag_event_cnt_next = mag_event_cnt_reg;
        mag_tick_cnt_next  = mag_tick_cnt_reg;
        repeat_cnt_next    = repeat_cnt_reg;
        valve_cnt_next     = valve_cnt_reg;
        flow_cnt_next      = flow_cnt_reg;
        prev_switch_next   = prev_switch_reg;
        armed_next         = armed_reg;
        last_pulse_next    = last_pulse_reg;
        mag_flag_next      = mag_flag_reg;
        stuck_flag_next    = stuck_flag_reg;
        leak_flag_next     = leak_flag_reg;
        flow_flag_next     = flow_flag_reg;
        inc                = '0;

        if (item.action == ACT_TICK)
        begin
            // ticks only watch for a held magnet
            mag_tick_cnt_next = '0;
            if (both_low && !mag_flag_reg)
            begin
                if (tick_inc >= TICK_LIMIT)
                begin
                    mag_flag_next = 1'b1;
                end
                else
                begin
                    mag_tick_cnt_next = tick_inc;
                end
            end
        end
        else
        begin
            // magnetic tampering
            if (both_low)
            begin
                mag_event_cnt_next = b_mag.cnt;
                mag_flag_next      = b_mag.flag;
            end
            else
            begin
                mag_event_cnt_next = '0;
                mag_flag_next      = 1'b0;
            end

            // stuck reed
            if (prev_switch_reg == this_switch)
            begin
                repeat_cnt_next = b_rep.cnt;
                stuck_flag_next = b_rep.flag;
            end
            else
            begin
                prev_switch_next = this_switch;
                repeat_cnt_next  = '0;
                stuck_flag_next  = 1'b0;
            end

            // valve leak
            if (item.valve_closed)
            begin
                valve_cnt_next = b_valve.cnt;
                leak_flag_next = b_valve.flag;
            end
            else
            begin
                valve_cnt_next = '0;
                leak_flag_next = 1'b0;
            end

            // pulse count and over-flow
            if (this_switch == SW_ONE && armed_reg)
            begin
                armed_next = 1'b0;
                inc        = cfg.pulse_weight;
                if (cfg.max_flow_interval != '0)
                begin
                    if (item.now_seconds > last_pulse_reg)
                    begin
                        last_pulse_next = item.now_seconds;
                    end
                    if (spacing <= cfg.max_flow_interval)
                    begin
                        flow_cnt_next  = b_flow.cnt;
                        flow_flag_next = b_flow.flag;
                    end
                    else
                    begin
                        flow_cnt_next = '0;
                    end
                end
            end
            if (this_switch == SW_TWO)
            begin
                armed_next = 1'b1;
            end
        end

        minute_next = minute_reg + inc;
        hour_next   = hour_reg + {8'd0, inc};
        total_next  = total_reg + {24'd0, inc};
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mag_event_cnt_reg <= '0;
            mag_tick_cnt_reg  <= '0;
            repeat_cnt_reg    <= '0;
            valve_cnt_reg     <= '0;
            flow_cnt_reg      <= '0;
            prev_switch_reg   <= SW_NONE;
            armed_reg         <= 1'b0;
            last_pulse_reg    <= '0;
            mag_flag_reg      <= 1'b0;
            stuck_flag_reg    <= 1'b0;
            leak_flag_reg     <= 1'b0;
            flow_flag_reg     <= 1'b0;
            minute_reg        <= '0;
            hour_reg          <= '0;
            total_reg         <= '0;
        end
        else if (step)
        begin
            mag_event_cnt_reg <= mag_event_cnt_next;
            mag_tick_cnt_reg  <= mag_tick_cnt_next;
            repeat_cnt_reg    <= repeat_cnt_next;
            valve_cnt_reg     <= valve_cnt_next;
            flow_cnt_reg      <= flow_cnt_next;
            prev_switch_reg   <= prev_switch_next;
            armed_reg         <= armed_next;
            last_pulse_reg    <= last_pulse_next;
            mag_flag_reg      <= mag_flag_next;
            stuck_flag_reg    <= stuck_flag_next;
            leak_flag_reg     <= leak_flag_next;
            flow_flag_reg     <= flow_flag_next;
            minute_reg        <= minute_next;
            hour_reg          <= hour_next;
            total_reg         <= total_next;
        end
    end

    // Result beat for this item
    always_comb
    begin
        result.increment        = inc;
        result.magnetic_fault   = mag_flag_next;
        result.stuck_reed_fault = stuck_flag_next;
        result.valve_leak_fault = leak_flag_next;
        result.over_flow_fault  = flow_flag_next;
        result.minute_sum       = minute_next;
        result.hour_sum         = hour_next;
        result.total_sum        = total_next;
    end

endmodule

/* src/dual_reed_pulse_counter.sv */
// Pulse counter and fault monitor for a meter with two reed switches.
// Item channel (item_valid/item_stall/item): one beat is either a reed
// switch event or a one-second tick, with the sampled pin levels, valve
// position and current time in seconds.
// Result channel (result_valid/result_stall/result): exactly one beat per
// item, carrying the counted increment, four fault flags and the minute,
// hour and total sums after that item.
// Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
// always high; write only while no item is outstanding.
// Output: the result beat is registered in the result register or skid entry.
// Throughput: one item per cycle while item_stall is low; all per-item work
// is a single pass of compare and increment logic ahead of the result register.
// Stall: a two-entry output buffer (result register plus skid) lets one
// more item in while the receiver stalls; item_stall then rises until the
// held beat drains.
// Reset: sums, counters and fault flags clear, no switch is remembered,
// pulse_weight returns to 1 and max_flow_interval to 0 (test off).
module dual_reed_pulse_counter
    import drpc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  item_t                item,
    output logic                 result_valid,
    input  logic                 result_stall,
    output result_t              result,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]           cfg_data
);

    cfg_t    cfg_reg;
    result_t core_result;
    result_t out_reg;
    result_t skid_reg;
    logic    out_valid_reg;
    logic    skid_valid_reg;
    logic    push;
    logic    pop;

    assign cfg_ready    = 1'b1;
    assign item_stall   = skid_valid_reg;
    assign push         = item_valid && !skid_valid_reg;
    assign pop          = out_valid_reg && !result_stall;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_weight      <= PULSE_WEIGHT_RST;
            cfg_reg.max_flow_interval <= MAX_FLOW_INTERVAL_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_PULSE_WEIGHT:      cfg_reg.pulse_weight      <= cfg_data;
                CFG_MAX_FLOW_INTERVAL: cfg_reg.max_flow_interval <= cfg_data;
                default:               ;
            endcase
        end
    end

    drpc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (push),
        .item   (item),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    // Output buffer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    // Output buffer payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= core_result;
            end
        end
        else if (push)
        begin
            if (out_valid_reg)
            begin
                skid_reg <= core_result;
            end
            else
            begin
                out_reg <= core_result;
            end
        end
    end

`ifndef NO_ASSERTIONS
    // skid entry only ever holds a beat behind a full result register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid beat held with empty result register");

    // every taken item is followed by a valid result beat next cycle
    a_item_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> result_valid)
        else $error("accepted item produced no result beat");

    // all three sums take the same increments, so the narrower ones are slices
    a_sums_agree: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.minute_sum == result.total_sum[7:0]) &&
                         (result.hour_sum == result.total_sum[15:0]))
        else $error("minute/hour sums disagree with total");

    // over-flow flag stays set once raised
    a_flow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && result.over_flow_fault && out_valid_reg) |=>
            (!result_valid || result.over_flow_fault))
        else $error("over-flow flag cleared");
`endif

endmodule

/* dv/tb_dual_reed_pulse_counter.sv */
`timescale 1ns / 100ps

module tb_dual_reed_pulse_counter
    import drpc_pkg::*;
();

    // Tracks what the meter front end should report and checks every result beat
    class reed_meter_checker;

        // register copies
        logic [7:0]  weight;
        logic [7:0]  flow_limit;

        // fault counters and flags
        logic [3:0]  mag_events;
        logic [2:0]  mag_ticks;
        logic [3:0]  repeats;
        logic [3:0]  closed_events;
        logic [3:0]  fast_pulses;
        logic        mag_flag;
        logic        stuck_flag;
        logic        leak_flag;
        logic        flow_flag;

        // pulse tracking and sums
        logic [1:0]  last_switch;
        logic        armed;
        logic [31:0] last_pulse;
        logic [7:0]  minute_acc;
        logic [15:0] hour_acc;
        logic [31:0] total_acc;

        result_t     pending_readings[$];

        int unsigned fail_count;
        int unsigned readings_checked;
        int unsigned events_seen;
        int unsigned ticks_seen;
        int unsigned pulses_counted;
        logic [3:0]  flags_raised;

        function new();
            weight        = PULSE_WEIGHT_RST;
            flow_limit    = MAX_FLOW_INTERVAL_RST;
            mag_events    = '0;
            mag_ticks     = '0;
            repeats       = '0;
            closed_events = '0;
            fast_pulses   = '0;
            mag_flag      = 1'b0;
            stuck_flag    = 1'b0;
            leak_flag     = 1'b0;
            flow_flag     = 1'b0;
            last_switch   = SW_NONE;
            armed         = 1'b0;
            last_pulse    = '0;
            minute_acc    = '0;
            hour_acc      = '0;
            total_acc     = '0;
            fail_count       = 0;
            readings_checked = 0;
            events_seen      = 0;
            ticks_seen       = 0;
            pulses_counted   = 0;
            flags_raised     = '0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [7:0] data);
            if (idx == CFG_PULSE_WEIGHT)
                weight = data;
            else if (idx == CFG_MAX_FLOW_INTERVAL)
                flow_limit = data;
        endfunction

        // one step towards a fault; the flag latches once the count passes the limit
        function void advance_fault(inout logic [3:0] cnt, inout logic flag);
            if (!flag)
            begin
                cnt = cnt + 4'd1;
                if (cnt > EVENT_LIMIT)
                begin
                    cnt  = '0;
                    flag = 1'b1;
                end
            end
            if (flag)
                cnt = '0;
        endfunction

        // accepted item beat: work out the reading it should produce
        function void take_item(item_t it);
            logic [7:0]  inc;
            logic [1:0]  sw;
            logic        both_low;
            logic [31:0] gap;
            logic [7:0]  spacing;
            result_t     rd;

            inc      = '0;
            sw       = {1'b0, it.which_switch};
            both_low = !it.switch_one_level && !it.switch_two_level;

            if (it.action == ACT_TICK)
            begin
                ticks_seen++;
                // ticks only feed the magnetic tamper count and never clear its flag
                if (both_low)
                begin
                    if (!mag_flag)
                    begin
                        mag_ticks = mag_ticks + 3'd1;
                        if (mag_ticks >= TICK_LIMIT)
                        begin
                            mag_ticks = '0;
                            mag_flag  = 1'b1;
                        end
                    end
                    if (mag_flag)
                        mag_ticks = '0;
                end
                else
                    mag_ticks = '0;
            end
            else
            begin
                events_seen++;
                if (both_low)
                    advance_fault(mag_events, mag_flag);
                else
                begin
                    mag_events = '0;
                    mag_flag   = 1'b0;
                end

                if (last_switch == sw)
                    advance_fault(repeats, stuck_flag);
                else
                begin
                    last_switch = sw;
                    repeats     = '0;
                    stuck_flag  = 1'b0;
                end

                if (it.valve_closed)
                    advance_fault(closed_events, leak_flag);
                else
                begin
                    closed_events = '0;
                    leak_flag     = 1'b0;
                end

                // switch one after switch two counts a pulse
                if (sw == SW_ONE && armed)
                begin
                    armed = 1'b0;
                    inc   = weight;
                    pulses_counted++;
                    if (flow_limit != 8'd0)
                    begin
                        spacing = '0;
                        // time going backwards or standing still gives zero spacing
                        if (it.now_seconds > last_pulse)
                        begin
                            gap        = it.now_seconds - last_pulse;
                            spacing    = (gap > 32'(SPACING_SAT)) ? SPACING_SAT : gap[7:0];
                            last_pulse = it.now_seconds;
                        end
                        if (spacing <= flow_limit)
                            advance_fault(fast_pulses, flow_flag);
                        else
                            fast_pulses = '0;
                    end
                end

                if (sw == SW_TWO)
                    armed = 1'b1;

                minute_acc = minute_acc + inc;
                hour_acc   = hour_acc + {8'd0, inc};
                total_acc  = total_acc + {24'd0, inc};
            end

            rd.increment        = inc;
            rd.magnetic_fault   = mag_flag;
            rd.stuck_reed_fault = stuck_flag;
            rd.valve_leak_fault = leak_flag;
            rd.over_flow_fault  = flow_flag;
            rd.minute_sum       = minute_acc;
            rd.hour_sum         = hour_acc;
            rd.total_sum        = total_acc;
            flags_raised |= {flow_flag, leak_flag, stuck_flag, mag_flag};
            pending_readings.push_back(rd);
        endfunction

        task report_mismatch(string msg);
            fail_count++;
            $display("[%0t] reading %0d: %s", $time, readings_checked, msg);
        endtask

        task compare_field(string field, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", field, got, want));
        endtask

        // accepted result beat against the oldest pending reading
        task match_result(result_t got);
            result_t want;

            if (pending_readings.size() == 0)
            begin
                report_mismatch("result beat with no reading pending");
                return;
            end
            want = pending_readings.pop_front();
            compare_field("increment", 32'(got.increment), 32'(want.increment));
            compare_field("magnetic_fault", 32'(got.magnetic_fault),
                          32'(want.magnetic_fault));
            compare_field("stuck_reed_fault", 32'(got.stuck_reed_fault),
                          32'(want.stuck_reed_fault));
            compare_field("valve_leak_fault", 32'(got.valve_leak_fault),
                          32'(want.valve_leak_fault));
            compare_field("over_flow_fault", 32'(got.over_flow_fault),
                          32'(want.over_flow_fault));
            compare_field("minute_sum", 32'(got.minute_sum), 32'(want.minute_sum));
            compare_field("hour_sum", 32'(got.hour_sum), 32'(want.hour_sum));
            compare_field("total_sum", got.total_sum, want.total_sum);
            readings_checked++;
        endtask

    endclass

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_stall;
    item_t                item_beat    = '0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    result_t              result_beat;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index    = '0;
    logic [7:0]           cfg_data     = '0;

    reed_meter_checker    sb;

    int unsigned          items_pushed = 0;
    int unsigned          burst_left   = 0;
    int unsigned          stall_mode   = 0;
    int unsigned          stall_left   = 0;
    int unsigned          settings     = 1;
    logic [31:0]          now_s        = '0;

    dual_reed_pulse_counter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item_beat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_beat),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver stall: picks a new random pattern each time its run counter expires
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 60);
        end
        else
            stall_left--;
        case (stall_mode)
            0:       result_stall <= 1'b0;
            1:       result_stall <= ($urandom_range(0, 3) == 0);
            2:       result_stall <= ($urandom_range(0, 3) != 0);
            default: result_stall <= (stall_left % 3 == 0);
        endcase
    end

    // watch all three channels at the rising edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.set_register(cfg_index, cfg_data);
            if (item_valid && !item_stall)
                sb.take_item(item_beat);
            if (result_valid && !result_stall)
                sb.match_result(result_beat);
        end
    end

    function automatic item_t make_beat(logic act, logic [1:0] sw, logic [1:0] lv,
                                        logic valve, logic [31:0] now);
        item_t it;
        it.action           = act;
        it.which_switch     = sw[0];
        it.switch_one_level = lv[1];
        it.switch_two_level = lv[0];
        it.valve_closed     = valve;
        it.now_seconds      = now;
        return it;
    endfunction

    // mostly short steps, some long ones, a few going back, rare jumps
    function automatic logic [31:0] step_time();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            now_s = now_s + $urandom_range(0, 3);
        else if (r < 80)
            now_s = now_s + $urandom_range(4, 300);
        else if (r < 92)
            now_s = now_s - $urandom_range(0, 40);
        else
            now_s = $urandom();
        return now_s;
    endfunction

    function automatic logic [1:0] pick_levels();
        if ($urandom_range(0, 7) == 0)
            return 2'b00;
        return 2'($urandom_range(1, 3));
    endfunction

    // send one beat; bursts of random length, mostly with idle gaps between them
    task automatic push_item(input item_t it);
        int unsigned gap;
        @(negedge clk);
        item_valid <= 1'b1;
        item_beat  <= it;
        do
            @(posedge clk);
        while (item_stall);
        items_pushed++;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                @(negedge clk);
                item_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        else
            burst_left--;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every reading has come back
    task automatic settle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (sb.pending_readings.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // random traffic, mostly well-formed arm/count pairs and fault runs
    task automatic run_random(input int unsigned n);
        int unsigned stop_at;
        int unsigned kind;
        int unsigned len;
        int unsigned k;
        logic [1:0]  sw;
        logic        valve;

        stop_at = items_pushed + n;
        while (items_pushed < stop_at)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++)
                begin
                    valve = ($urandom_range(0, 9) == 0);
                    push_item(make_beat(ACT_EVENT, SW_TWO, pick_levels(), valve, now_s));
                    push_item(make_beat(ACT_EVENT, SW_ONE, pick_levels(), valve, step_time()));
                    if ($urandom_range(0, 4) == 0)
                        push_item(make_beat(ACT_TICK, 2'($urandom_range(0, 1)),
                                            2'($urandom_range(0, 3)),
                                            1'($urandom_range(0, 1)), now_s));
                end
            end
            else if (kind < 55)
            begin
                // magnetic tamper via events
                len = $urandom_range(9, 13);
                for (k = 0; k < len; k++)
                    push_item(make_beat(ACT_EVENT, (k % 2 == 0) ? SW_TWO : SW_ONE, 2'b00,
                                        1'($urandom_range(0, 1)), step_time()));
            end
            else if (kind < 63)
            begin
                // magnetic tamper via ticks
                len = $urandom_range(3, 7);
                for (k = 0; k < len; k++)
                    push_item(make_beat(ACT_TICK, 2'($urandom_range(0, 1)),
                                        ($urandom_range(0, 9) == 0) ? pick_levels() : 2'b00,
                                        1'($urandom_range(0, 1)), step_time()));
            end
            else if (kind < 73)
            begin
                // stuck reed: one switch repeating
                sw  = 2'($urandom_range(0, 1));
                len = $urandom_range(9, 14);
                for (k = 0; k < len; k++)
                    push_item(make_beat(ACT_EVENT, sw, pick_levels(), 1'b0, step_time()));
            end
            else if (kind < 83)
            begin
                // counting with the valve closed
                len = $urandom_range(9, 14);
                for (k = 0; k < len; k++)
                    push_item(make_beat(ACT_EVENT, (k % 2 == 0) ? SW_TWO : SW_ONE,
                                        pick_levels(), 1'b1, step_time()));
            end
            else
            begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++)
                    push_item(make_beat(1'($urandom_range(0, 1)), 2'($urandom_range(0, 1)),
                                        2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                        $urandom()));
            end
        end
    endtask

    initial
    begin
        sb = new();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: tick tamper, clearing, pulse counting at time extremes
        push_item(make_beat(ACT_TICK, SW_ONE, 2'b11, 1'b0, 32'd0));
        repeat (6) push_item(make_beat(ACT_TICK, SW_ONE, 2'b00, 1'b0, 32'd0));
        push_item(make_beat(ACT_EVENT, SW_ONE, 2'b00, 1'b0, 32'd0));
        push_item(make_beat(ACT_EVENT, SW_TWO, 2'b11, 1'b0, 32'd0));
        push_item(make_beat(ACT_EVENT, SW_ONE, 2'b11, 1'b0, 32'hffff_ffff));
        push_item(make_beat(ACT_EVENT, SW_ONE, 2'b11, 1'b0, 32'hffff_ffff));
        push_item(make_beat(ACT_EVENT, SW_TWO, 2'b01, 1'b1, 32'd0));
        push_item(make_beat(ACT_EVENT, SW_ONE, 2'b10, 1'b1, 32'd0));
        push_item(make_beat(ACT_TICK, SW_TWO, 2'b10, 1'b1, 32'hffff_ffff));
        run_random(170);
        settle();

        write_reg(CFG_PULSE_WEIGHT, 8'd255);
        settings++;
        run_random(150);
        settle();

        // narrowest limit: spacing steps, time going back, saturation
        write_reg(CFG_PULSE_WEIGHT, 8'd0);
        write_reg(CFG_MAX_FLOW_INTERVAL, 8'd1);
        settings++;
        push_item(make_beat(ACT_EVENT, SW_TWO, 2'b11, 1'b0, 32'd100));
        push_item(make_beat(ACT_EVENT, SW_ONE, 2'b11, 1'b0, 32'd100));
        push_item(make_beat(ACT_EVENT, SW_TWO, 2'b11, 1'b0, 32'd101));
        push_item(make_beat(ACT_EVENT, SW_ONE, 2'b11, 1'b0, 32'd101));
        push_item(make_beat(ACT_EVENT, SW_TWO, 2'b11, 1'b0, 32'd50));
        push_item(make_beat(ACT_EVENT, SW_ONE, 2'b11, 1'b0, 32'd50));
        push_item(make_beat(ACT_EVENT, SW_TWO, 2'b11, 1'b0, 32'd2000));
        push_item(make_beat(ACT_EVENT, SW_ONE, 2'b11, 1'b0, 32'd2000));
        push_item(make_beat(ACT_EVENT, SW_TWO, 2'b11, 1'b0, 32'hffff_ffff));
        push_item(make_beat(ACT_EVENT, SW_ONE, 2'b11, 1'b0, 32'hffff_ffff));
        now_s = 32'd4000;
        run_random(150);
        settle();

        write_reg(CFG_PULSE_WEIGHT, 8'($urandom_range(1, 254)));
        write_reg(CFG_MAX_FLOW_INTERVAL, 8'($urandom_range(2, 40)));
        settings++;
        run_random(200);
        settle();

        write_reg(CFG_PULSE_WEIGHT, 8'd255);
        write_reg(CFG_MAX_FLOW_INTERVAL, 8'd255);
        settings++;
        run_random(200);
        settle();

        if (sb.pending_readings.size() != 0)
            sb.report_mismatch("readings still pending at end of run");

        $display("Checked %0d readings: %0d reed events, %0d ticks, %0d counted pulses,",
                 sb.readings_checked, sb.events_seen, sb.ticks_seen, sb.pulses_counted);
        $display("over %0d settings; faults raised: magnetic %0b, stuck reed %0b, %s%0b, %s%0b",
                 settings, sb.flags_raised[0], sb.flags_raised[1],
                 "valve leak ", sb.flags_raised[2], "over-flow ", sb.flags_raised[3]);
        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

/* dual_reed_pulse_counter.f */
src/drpc_pkg.sv
src/drpc_core.sv
src/dual_reed_pulse_counter.sv
dv/tb_dual_reed_pulse_counter.sv
